/* hdl/awh_pkg.sv */
// Shared types and constants for the archive block header walker.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package awh_pkg;

   // Build-time constants
   localparam int SIGNATURE_BYTES   = 7;
   localparam int ENTRY_COUNT_WIDTH = 16;

   // Field widths fixed by the byte stream and result format
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 32;
   localparam int LEN_W   = 32;
   localparam int HSIZE_W = 16;
   localparam int NLEN_W  = 16;
   localparam int IDX_W   = 5;
   localparam int ENTRY_W = 16;
   localparam int NBS_W   = 34;
   localparam int HEND_W  = 33;

   // Block type that carries a file head
   localparam logic [BYTE_W-1:0] FILE_BLOCK_TYPE = 8'h74;
   // Bytes in the common block header
   localparam int HEADER_BYTES  = 7;
   // Offset of the first name byte from the block start
   localparam int FILE_HEAD_END = 32;

   // Byte offsets inside a block (relative to the block start)
   localparam logic [IDX_W-1:0] OFS_TYPE       = 5'd2;
   localparam logic [IDX_W-1:0] OFS_HSIZE_LO   = 5'd5;
   localparam logic [IDX_W-1:0] OFS_HSIZE_HI   = 5'd6;
   localparam logic [IDX_W-1:0] OFS_PACK_0     = 5'd7;
   localparam logic [IDX_W-1:0] OFS_PACK_1     = 5'd8;
   localparam logic [IDX_W-1:0] OFS_PACK_2     = 5'd9;
   localparam logic [IDX_W-1:0] OFS_PACK_3     = 5'd10;
   localparam logic [IDX_W-1:0] OFS_PACK_DONE  = 5'd11;
   localparam logic [IDX_W-1:0] OFS_NLEN_LO    = 5'd26;
   localparam logic [IDX_W-1:0] OFS_NLEN_HI    = 5'd27;
   localparam logic [IDX_W-1:0] OFS_HEAD_LAST  = 5'd31;

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_HEAD = 3'd1,
      PH_FILE = 3'd2,
      PH_NAME = 3'd3,
      PH_DONE = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_SKIP  = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              final_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  name_char;
      logic               name_valid;
      logic [ENTRY_W-1:0] entry_number;
      logic               name_end;
      logic               scan_done;
      logic [1:0]         scan_status;
   } rsp_item_type;

   // Input register contents handed to the walker
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

endpackage

/* hdl/awh_in_reg.sv */
// Input register for the byte stream: captures one beat, drives req_stall.
// Depends on awh_pkg.
`timescale 1ns / 1ps

module awh_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  awh_pkg::req_item_type req_data,
   input  logic                 advance,
   output awh_pkg::stage_type   stage
);
   import awh_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   // Hold the beat while the walker cannot take it
   assign req_stall = valid_ff & ~advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            item_in = req_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

/* hdl/awh_walker.sv */
// Block chain walker: per-byte state update and result formation.
// Depends on awh_pkg.
`timescale 1ns / 1ps

module awh_walker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  awh_pkg::req_item_type   item,
   input  logic [awh_pkg::LEN_W-1:0] file_length,
   output logic                    emit,
   output awh_pkg::rsp_item_type   result
);
   import awh_pkg::*;

   localparam int CNT_W = ENTRY_COUNT_WIDTH;

   logic [POS_W-1:0]   pos_ff, pos_in;
   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [BYTE_W-1:0]  kind_ff, kind_in;
   logic [HSIZE_W-1:0] hsize_ff, hsize_in;
   logic [LEN_W-1:0]   packed_ff, packed_in;
   logic [NLEN_W-1:0]  nlen_ff, nlen_in;
   logic [POS_W-1:0]   bs_ff, bs_in;
   logic [NBS_W-1:0]   nbs_ff, nbs_in;
   logic [HEND_W-1:0]  hend_ff, hend_in;
   logic [NBS_W-1:0]   target_ff, target_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   status_type         status_ff, status_in;

   logic [BYTE_W-1:0]  b;
   logic [HSIZE_W-1:0] hs;
   logic [NLEN_W-1:0]  nl;
   logic [HEND_W-1:0]  hend_calc;
   logic [HEND_W-1:0]  name_bound;
   logic [HEND_W-1:0]  head_bound;
   logic [NBS_W:0]     hdr_bound;
   logic [CNT_W-1:0]   cnt_inc;
   phase_type          ph_cur;
   logic [IDX_W-1:0]   k;
   logic               adv_req;
   logic [NBS_W-1:0]   adv_target;
   status_type         fin_status;

   always_comb begin
      b          = item.data_byte;
      hs         = {b, hsize_ff[BYTE_W-1:0]};
      nl         = {b, nlen_ff[BYTE_W-1:0]};
      hend_calc  = {1'b0, bs_ff} + HEND_W'(hs);
      name_bound = {1'b0, bs_ff} + HEND_W'(FILE_HEAD_END) + HEND_W'(nl);
      head_bound = {1'b0, bs_ff} + HEND_W'(FILE_HEAD_END);
      hdr_bound  = {1'b0, nbs_ff} + (NBS_W+1)'(HEADER_BYTES);
      cnt_inc    = cnt_ff + CNT_W'(1);
      if (cnt_inc == '0) begin
         cnt_inc = CNT_W'(1);
      end

      pos_in     = pos_ff;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      kind_in    = kind_ff;
      hsize_in   = hsize_ff;
      packed_in  = packed_ff;
      nlen_in    = nlen_ff;
      bs_in      = bs_ff;
      nbs_in     = nbs_ff;
      hend_in    = hend_ff;
      target_in  = target_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      ph_cur     = phase_ff;
      k          = idx_ff;
      adv_req    = 1'b0;
      adv_target = target_ff;
      fin_status = ST_OK;
      emit       = 1'b0;
      result     = '0;
      result.entry_number = ENTRY_W'(cnt_ff);

      if (step) begin
         if (pos_ff != '1) begin
            pos_in = pos_ff + POS_W'(1);
         end

         // Block start reached: bounds check, then open the header
         if (phase_ff == PH_WAIT && {2'b00, pos_ff} == nbs_ff) begin
            if (nbs_ff >= NBS_W'(file_length)) begin
               ph_cur    = PH_DONE;
               status_in = ST_OK;
            end else if (hdr_bound > (NBS_W+1)'(file_length)) begin
               ph_cur    = PH_DONE;
               status_in = ST_TRUNC;
            end else begin
               ph_cur    = PH_HEAD;
               bs_in     = pos_ff;
               k         = '0;
               kind_in   = '0;
               hsize_in  = '0;
               packed_in = '0;
               nlen_in   = '0;
            end
         end
         phase_in = ph_cur;

         case (ph_cur)
            PH_HEAD: begin
               case (k)
                  OFS_TYPE: begin
                     kind_in = b;
                     if (b == FILE_BLOCK_TYPE && head_bound > HEND_W'(file_length)) begin
                        phase_in  = PH_DONE;
                        status_in = ST_TRUNC;
                     end
                  end
                  OFS_HSIZE_LO: hsize_in = HSIZE_W'(b);
                  OFS_HSIZE_HI: begin
                     hsize_in = hs;
                     hend_in  = hend_calc;
                     if (kind_ff == FILE_BLOCK_TYPE) begin
                        phase_in = PH_FILE;
                     end else begin
                        adv_req    = 1'b1;
                        adv_target = NBS_W'(hend_calc);
                     end
                  end
                  default: ;
               endcase
               idx_in = k + IDX_W'(1);
            end
            PH_FILE: begin
               case (k)
                  OFS_PACK_0:    packed_in[7:0]   = b;
                  OFS_PACK_1:    packed_in[15:8]  = b;
                  OFS_PACK_2:    packed_in[23:16] = b;
                  OFS_PACK_3:    packed_in[31:24] = b;
                  OFS_PACK_DONE: target_in = NBS_W'(hend_ff) + NBS_W'(packed_ff);
                  OFS_NLEN_LO:   nlen_in = NLEN_W'(b);
                  OFS_NLEN_HI: begin
                     nlen_in = nl;
                     if (name_bound > HEND_W'(file_length)) begin
                        phase_in  = PH_DONE;
                        status_in = ST_TRUNC;
                     end
                  end
                  OFS_HEAD_LAST: begin
                     if (nlen_ff == '0) begin
                        // Empty name: marker item only
                        emit            = 1'b1;
                        result.name_end = 1'b1;
                        cnt_in          = cnt_inc;
                        adv_req         = 1'b1;
                     end else begin
                        phase_in = PH_NAME;
                     end
                  end
                  default: ;
               endcase
               idx_in = k + IDX_W'(1);
            end
            PH_NAME: begin
               emit              = 1'b1;
               result.name_char  = b;
               result.name_valid = 1'b1;
               result.name_end   = (nlen_ff <= NLEN_W'(1));
               if (nlen_ff != '0) begin
                  nlen_in = nlen_ff - NLEN_W'(1);
               end
               if (nlen_ff <= NLEN_W'(1)) begin
                  cnt_in  = cnt_inc;
                  adv_req = 1'b1;
               end
            end
            default: ;
         endcase

         // Skip to the next block; a zero or backward skip stops the scan
         if (adv_req) begin
            if (adv_target <= NBS_W'(pos_ff)) begin
               phase_in  = PH_DONE;
               status_in = ST_SKIP;
            end else begin
               nbs_in   = adv_target;
               phase_in = PH_WAIT;
            end
         end

         if (item.final_byte) begin
            unique case (phase_in)
               PH_DONE: fin_status = status_in;
               PH_WAIT: fin_status = (nbs_in >= NBS_W'(file_length)) ? ST_OK : ST_TRUNC;
               default: fin_status = ST_TRUNC;
            endcase
            emit               = 1'b1;
            result.scan_done   = 1'b1;
            result.scan_status = fin_status;
            // Return to the reset state for the next archive
            pos_in    = '0;
            phase_in  = PH_WAIT;
            idx_in    = '0;
            kind_in   = '0;
            hsize_in  = '0;
            packed_in = '0;
            nlen_in   = '0;
            bs_in     = POS_W'(SIGNATURE_BYTES);
            nbs_in    = NBS_W'(SIGNATURE_BYTES);
            cnt_in    = CNT_W'(1);
            status_in = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_WAIT;
         idx_ff    <= '0;
         kind_ff   <= '0;
         hsize_ff  <= '0;
         packed_ff <= '0;
         nlen_ff   <= '0;
         bs_ff     <= POS_W'(SIGNATURE_BYTES);
         nbs_ff    <= NBS_W'(SIGNATURE_BYTES);
         cnt_ff    <= CNT_W'(1);
         status_ff <= ST_OK;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         kind_ff   <= kind_in;
         hsize_ff  <= hsize_in;
         packed_ff <= packed_in;
         nlen_ff   <= nlen_in;
         bs_ff     <= bs_in;
         nbs_ff    <= nbs_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
      hend_ff   <= hend_in;
      target_ff <= target_in;
   end

endmodule

/* hdl/archive_block_header_walker.sv */
// Archive block header walker: one archive byte per beat in, name bytes and
// end-of-scan status out. An accepted beat passes from the input register
// through the walker state update into the result register behind rsp_valid.
// Throughput: one byte per cycle while no stalled result beat holds the input.
// Reset (synchronous): clears walker state, file_length and both beat valid flags.
`timescale 1ns / 1ps

module archive_block_header_walker (
   input  logic                  clock,
   input  logic                  reset,
   // byte stream
   input  logic                  req_valid,
   output logic                  req_stall,
   input  awh_pkg::req_item_type req_data,
   // result stream
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output awh_pkg::rsp_item_type rsp_data,
   // file length register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data
);
   import awh_pkg::*;

   stage_type         stage;
   logic              advance;
   logic              step;
   logic              emit;
   rsp_item_type      result;

   logic [LEN_W-1:0]  file_length_ff, file_length_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   // Configuration: always ready; written only while the walker is idle is a rule for the user, not enforced here
   assign csr_ready = 1'b1;

   always_comb begin
      file_length_in = file_length_ff;
      if (csr_valid && csr_ready) begin
         file_length_in = csr_data;
      end
   end

   // Move the held beat into the walker whenever the result register is
   // empty or drains this cycle; a stalled result that is waiting holds the
   // staged byte and stalls the input.
   assign advance = ~rsp_valid_ff | ~rsp_stall;
   assign step    = stage.valid & advance;

   awh_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .stage     (stage)
   );

   awh_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (stage.item),
      .file_length (file_length_ff),
      .emit        (emit),
      .result      (result)
   );

   // Result register: load on a producing step, hold while stalled,
   // drop valid once the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (step && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         file_length_ff <= file_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/awh_checker.sv */
// Port-level checks for the archive block header walker, bound to the top.
// Depends on awh_pkg and archive_block_header_walker.
`timescale 1ns / 1ps

module awh_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input awh_pkg::rsp_item_type rsp_data
);
   import awh_pkg::*;

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Status-only beats carry no name byte
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.name_valid |-> rsp_data.name_char == '0)
      else $error("name_char set without name_valid");

   // Status is reported only on the closing beat
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.scan_done |-> rsp_data.scan_status == ST_OK)
      else $error("scan_status set before scan end");

   // Mid-scan beats are name bytes or empty-name markers
   a_mid_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.scan_done |-> rsp_data.name_valid || rsp_data.name_end)
      else $error("mid-scan beat carries nothing");

   // Entry numbers are one-based
   a_entry_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_number != '0)
      else $error("entry number is zero");

endmodule

bind archive_block_header_walker awh_checker u_awh_checker (.*);
